// ===== sv/psct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character classes of the pipe-separated cell tokenizer.
package psct_pkg;

  localparam int unsigned BLANK_BUFFER_DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(BLANK_BUFFER_DEPTH + 1);
  localparam int unsigned IDX_W = (BLANK_BUFFER_DEPTH > 1) ? $clog2(BLANK_BUFFER_DEPTH) : 1;

  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    K_CONTENT = 2'd0,
    K_CELL    = 2'd1,
    K_ROW     = 2'd2,
    K_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_UNCLOSED = 2'd0,
    ERR_JUNK     = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef enum logic [9:0] {
    M_FILE_START  = 10'b00_0000_0001,
    M_LINE_START  = 10'b00_0000_0010,
    M_LEAD_BLANK  = 10'b00_0000_0100,
    M_HEADER      = 10'b00_0000_1000,
    M_COMMENT     = 10'b00_0001_0000,
    M_CELL_START  = 10'b00_0010_0000,
    M_UNQUOTED    = 10'b00_0100_0000,
    M_QUOTED      = 10'b00_1000_0000,
    M_QUOTE_SEEN  = 10'b01_0000_0000,
    M_AFTER_QUOTE = 10'b10_0000_0000
  } mode_t;

  typedef enum logic [3:0] {
    SQ_IDLE  = 4'b0001,
    SQ_FLUSH = 4'b0010,
    SQ_MAIN  = 4'b0100,
    SQ_ROW   = 4'b1000
  } seq_t;

  // Results of one request: held blanks first, then one token, then maybe a row end.
  typedef struct packed {
    logic [CNT_W-1:0] flush_len;
    logic             has_main;
    kind_t            main_kind;
    logic [7:0]       main_byte;
    err_t             main_err;
    logic             row_end;
  } plan_t;

  // Write into the held-blank buffer.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } blank_wr_t;

  function automatic logic is_line_end(input logic [7:0] c);
    return (c inside {CH_CR, CH_LF});
  endfunction

  function automatic logic is_cell_blank(input logic [7:0] c);
    return (c inside {CH_SPACE, CH_TAB, CH_VT});
  endfunction

  function automatic logic is_lead_blank(input logic [7:0] c);
    return (c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF});
  endfunction

endpackage

// ===== sv/psct_if.sv =====
`timescale 1ns / 1ps
// Request and result channel interfaces of the tokenizer.
interface psct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface psct_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] content_byte;
  logic [1:0] error_code;
  logic       last_result;

  modport source (output valid, output token_kind, output content_byte,
                  output error_code, output last_result, input ready);
  modport sink   (input valid, input token_kind, input content_byte,
                  input error_code, input last_result, output ready);
endinterface

// ===== sv/psct_blank_buf.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, one read port with registered read data.
module psct_blank_buf #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Store on write; contents need no reset. Read data is registered and shows up in the cycle after the address.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/psct_lexer.sv =====
`timescale 1ns / 1ps
// Lexer state and per-byte decision: next mode and the results one request causes.
module psct_lexer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_input,
  output psct_pkg::plan_t       plan,
  output psct_pkg::blank_wr_t   wr
);

  psct_pkg::mode_t             mode_r, mode_nxt;
  logic [psct_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        cr_r, cr_nxt;
  logic                        halt_r, halt_nxt;
  logic                        do_cell_start;
  logic                        do_after_quote;
  logic                        do_end_row;
  logic                        wr_en;

  always_comb begin
    mode_nxt       = mode_r;
    cnt_nxt        = cnt_r;
    cr_nxt         = cr_r;
    halt_nxt       = halt_r;
    plan           = '0;
    wr_en          = 1'b0;
    wr.idx         = cnt_r[psct_pkg::IDX_W-1:0];
    wr.data        = data_byte;
    do_cell_start  = 1'b0;
    do_after_quote = 1'b0;
    do_end_row     = 1'b0;

    if (end_of_input) begin
      if (!halt_r) begin
        if (mode_r == psct_pkg::M_QUOTED) begin
          plan.has_main  = 1'b1;
          plan.main_kind = psct_pkg::K_ERROR;
          plan.main_err  = psct_pkg::ERR_UNCLOSED;
        end else if (mode_r == psct_pkg::M_CELL_START || mode_r == psct_pkg::M_UNQUOTED ||
                     mode_r == psct_pkg::M_QUOTE_SEEN || mode_r == psct_pkg::M_AFTER_QUOTE) begin
          plan.has_main  = 1'b1;
          plan.main_kind = psct_pkg::K_CELL;
          plan.row_end   = 1'b1;
        end
      end
      mode_nxt = psct_pkg::M_FILE_START;
      cnt_nxt  = '0;
      cr_nxt   = 1'b0;
      halt_nxt = 1'b0;
    end else if (halt_r) begin
      // drop every byte until end of input
    end else if (cr_r && data_byte == psct_pkg::CH_LF) begin
      cr_nxt = 1'b0;
    end else begin
      cr_nxt = 1'b0;
      case (mode_r)
        psct_pkg::M_FILE_START, psct_pkg::M_LINE_START: begin
          if (mode_r == psct_pkg::M_FILE_START && data_byte == psct_pkg::CH_LBRACK) begin
            mode_nxt = psct_pkg::M_HEADER;
          end else if (data_byte == psct_pkg::CH_SEMI) begin
            mode_nxt = psct_pkg::M_COMMENT;
          end else if (psct_pkg::is_line_end(data_byte)) begin
            cr_nxt   = (data_byte == psct_pkg::CH_CR);
            mode_nxt = psct_pkg::M_LINE_START;
          end else if (psct_pkg::is_lead_blank(data_byte)) begin
            mode_nxt = psct_pkg::M_LEAD_BLANK;
          end else begin
            do_cell_start = 1'b1;
          end
        end
        psct_pkg::M_LEAD_BLANK: begin
          if (psct_pkg::is_line_end(data_byte)) begin
            cr_nxt   = (data_byte == psct_pkg::CH_CR);
            mode_nxt = psct_pkg::M_LINE_START;
          end else if (!psct_pkg::is_lead_blank(data_byte)) begin
            do_cell_start = 1'b1;
          end
        end
        psct_pkg::M_HEADER, psct_pkg::M_COMMENT: begin
          if (psct_pkg::is_line_end(data_byte)) begin
            cr_nxt   = (data_byte == psct_pkg::CH_CR);
            mode_nxt = psct_pkg::M_LINE_START;
          end
        end
        psct_pkg::M_CELL_START: begin
          do_cell_start = 1'b1;
        end
        psct_pkg::M_UNQUOTED: begin
          if (data_byte == psct_pkg::CH_PIPE) begin
            cnt_nxt        = '0;
            plan.has_main  = 1'b1;
            plan.main_kind = psct_pkg::K_CELL;
            mode_nxt       = psct_pkg::M_CELL_START;
          end else if (psct_pkg::is_line_end(data_byte)) begin
            do_end_row = 1'b1;
          end else if (psct_pkg::is_cell_blank(data_byte)) begin
            if (cnt_r >= psct_pkg::CNT_W'(psct_pkg::BLANK_BUFFER_DEPTH)) begin
              cnt_nxt        = '0;
              plan.has_main  = 1'b1;
              plan.main_kind = psct_pkg::K_ERROR;
              plan.main_err  = psct_pkg::ERR_OVERFLOW;
              halt_nxt       = 1'b1;
            end else begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + psct_pkg::CNT_W'(1);
            end
          end else begin
            // release held blanks ahead of the content byte
            plan.flush_len = cnt_r;
            cnt_nxt        = '0;
            plan.has_main  = 1'b1;
            plan.main_kind = psct_pkg::K_CONTENT;
            plan.main_byte = data_byte;
          end
        end
        psct_pkg::M_QUOTED: begin
          if (data_byte == psct_pkg::CH_QUOTE) begin
            mode_nxt = psct_pkg::M_QUOTE_SEEN;
          end else begin
            plan.has_main  = 1'b1;
            plan.main_kind = psct_pkg::K_CONTENT;
            plan.main_byte = data_byte;
          end
        end
        psct_pkg::M_QUOTE_SEEN: begin
          if (data_byte == psct_pkg::CH_QUOTE) begin
            plan.has_main  = 1'b1;
            plan.main_kind = psct_pkg::K_CONTENT;
            plan.main_byte = data_byte;
            mode_nxt       = psct_pkg::M_QUOTED;
          end else begin
            do_after_quote = 1'b1;
          end
        end
        psct_pkg::M_AFTER_QUOTE: begin
          do_after_quote = 1'b1;
        end
        default: begin
          mode_nxt = psct_pkg::M_LINE_START;
        end
      endcase
    end

    if (do_cell_start) begin
      cnt_nxt = '0;
      if (data_byte == psct_pkg::CH_QUOTE) begin
        mode_nxt = psct_pkg::M_QUOTED;
      end else if (data_byte == psct_pkg::CH_PIPE) begin
        plan.has_main  = 1'b1;
        plan.main_kind = psct_pkg::K_CELL;
        mode_nxt       = psct_pkg::M_CELL_START;
      end else if (psct_pkg::is_line_end(data_byte)) begin
        do_end_row = 1'b1;
      end else if (psct_pkg::is_cell_blank(data_byte)) begin
        wr_en    = 1'b1;
        wr.idx   = '0;
        cnt_nxt  = psct_pkg::CNT_W'(1);
        mode_nxt = psct_pkg::M_UNQUOTED;
      end else begin
        plan.has_main  = 1'b1;
        plan.main_kind = psct_pkg::K_CONTENT;
        plan.main_byte = data_byte;
        mode_nxt       = psct_pkg::M_UNQUOTED;
      end
    end

    if (do_after_quote) begin
      if (data_byte == psct_pkg::CH_PIPE) begin
        plan.has_main  = 1'b1;
        plan.main_kind = psct_pkg::K_CELL;
        mode_nxt       = psct_pkg::M_CELL_START;
      end else if (psct_pkg::is_line_end(data_byte)) begin
        do_end_row = 1'b1;
      end else if (psct_pkg::is_cell_blank(data_byte)) begin
        mode_nxt = psct_pkg::M_AFTER_QUOTE;
      end else begin
        plan.has_main  = 1'b1;
        plan.main_kind = psct_pkg::K_ERROR;
        plan.main_err  = psct_pkg::ERR_JUNK;
        halt_nxt       = 1'b1;
      end
    end

    if (do_end_row) begin
      cnt_nxt        = '0;
      plan.has_main  = 1'b1;
      plan.main_kind = psct_pkg::K_CELL;
      plan.row_end   = 1'b1;
      cr_nxt         = (data_byte == psct_pkg::CH_CR);
      mode_nxt       = psct_pkg::M_LINE_START;
    end

    wr.en = wr_en && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= psct_pkg::M_FILE_START;
      cnt_r  <= '0;
      cr_r   <= 1'b0;
      halt_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      cr_r   <= cr_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// ===== sv/pipe_separated_cell_tokenizer.sv =====
`timescale 1ns / 1ps
// Top level of the pipe-separated cell tokenizer: lexer, blank buffer and result sequencer.
//
// Each request carries one text byte or an end-of-input mark; the block answers with
// a stream of tokens (content byte, cell end, row end, error), the last token of a
// request flagged by last_result. Header, comment and blank lines and leading blanks
// are skipped, quoted cells unescape doubled quotes, and trailing blanks of unquoted
// cells are held in a buffer of BLANK_BUFFER_DEPTH entries and released only when
// more content follows. The block takes one request at a time: the result sequencer
// moves one token per cycle into the output register while the result side keeps
// ready high (held blanks go out first, read one per cycle from the blank buffer,
// then the main token and any row end). The output register lets the next request
// in while the final token still waits to be taken. After an error the block drops
// bytes without results until end of input.
module pipe_separated_cell_tokenizer (
  input  logic             clk,
  input  logic             rst_n,
  psct_in_if.sink          in_ch,
  psct_out_if.source       out_ch
);

  psct_pkg::plan_t             plan;
  psct_pkg::plan_t             plan_r;
  psct_pkg::blank_wr_t         blank_wr;
  psct_pkg::seq_t              seq_r, seq_nxt;
  logic [psct_pkg::CNT_W-1:0]  flush_idx_r, flush_idx_nxt;
  logic [7:0]                  blank_rd;
  logic                        accept;
  logic                        can_load;
  logic                        load;
  psct_pkg::kind_t             ld_kind;
  logic [7:0]                  ld_byte;
  psct_pkg::err_t              ld_err;
  logic                        ld_last;

  logic                        out_valid_r;
  psct_pkg::kind_t             out_kind_r;
  logic [7:0]                  out_byte_r;
  psct_pkg::err_t              out_err_r;
  logic                        out_last_r;

  // Take a request only while the sequencer has nothing left to emit.
  assign in_ch.ready = (seq_r == psct_pkg::SQ_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign can_load    = !out_valid_r || out_ch.ready;

  psct_lexer u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_ch.data_byte),
    .end_of_input (in_ch.end_of_input),
    .plan         (plan),
    .wr           (blank_wr)
  );

  // Address the buffer with the next flush index, so the blank at flush_idx_r
  // is already on blank_rd while the sequencer sits on it.
  psct_blank_buf #(
    .WIDTH  (8),
    .DEPTH  (psct_pkg::BLANK_BUFFER_DEPTH),
    .ADDR_W (psct_pkg::IDX_W)
  ) u_blank_buf (
    .clk     (clk),
    .wr_en   (blank_wr.en),
    .wr_addr (blank_wr.idx),
    .wr_data (blank_wr.data),
    .rd_addr (flush_idx_nxt[psct_pkg::IDX_W-1:0]),
    .rd_data (blank_rd)
  );

  // Result sequencer: flush held blanks, then the main token, then a row end.
  always_comb begin
    seq_nxt       = seq_r;
    flush_idx_nxt = flush_idx_r;
    load          = 1'b0;
    ld_kind       = psct_pkg::K_CONTENT;
    ld_byte       = '0;
    ld_err        = psct_pkg::ERR_UNCLOSED;
    ld_last       = 1'b0;
    case (seq_r)
      psct_pkg::SQ_IDLE: begin
        if (accept) begin
          flush_idx_nxt = '0;
          if (plan.flush_len != '0) begin
            seq_nxt = psct_pkg::SQ_FLUSH;
          end else if (plan.has_main) begin
            seq_nxt = psct_pkg::SQ_MAIN;
          end
        end
      end
      psct_pkg::SQ_FLUSH: begin
        if (can_load) begin
          load          = 1'b1;
          ld_byte       = blank_rd;
          flush_idx_nxt = flush_idx_r + psct_pkg::CNT_W'(1);
          if (flush_idx_nxt == plan_r.flush_len) begin
            seq_nxt = psct_pkg::SQ_MAIN;
          end
        end
      end
      psct_pkg::SQ_MAIN: begin
        if (can_load) begin
          load    = 1'b1;
          ld_kind = plan_r.main_kind;
          ld_byte = (plan_r.main_kind == psct_pkg::K_CONTENT) ? plan_r.main_byte : 8'h00;
          ld_err  = (plan_r.main_kind == psct_pkg::K_ERROR) ? plan_r.main_err
                                                             : psct_pkg::ERR_UNCLOSED;
          ld_last = !plan_r.row_end;
          seq_nxt = plan_r.row_end ? psct_pkg::SQ_ROW : psct_pkg::SQ_IDLE;
        end
      end
      psct_pkg::SQ_ROW: begin
        if (can_load) begin
          load    = 1'b1;
          ld_kind = psct_pkg::K_ROW;
          ld_last = 1'b1;
          seq_nxt = psct_pkg::SQ_IDLE;
        end
      end
      default: begin
        seq_nxt = psct_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= psct_pkg::SQ_IDLE;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  // Hold the plan and flush position of the request in progress.
  always_ff @(posedge clk) begin
    flush_idx_r <= flush_idx_nxt;
    if (accept) begin
      plan_r <= plan;
    end
  end

  // Output register: advance when empty or taken, else hold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r <= ld_kind;
      out_byte_r <= ld_byte;
      out_err_r  <= ld_err;
      out_last_r <= ld_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_kind   = out_kind_r;
  assign out_ch.content_byte = out_byte_r;
  assign out_ch.error_code   = out_err_r;
  assign out_ch.last_result  = out_last_r;

`ifndef ASSERT_OFF
  // A new request arrives only once the previous one has shown its final token.
  a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!out_valid_r || out_last_r))
    else $error("request accepted while earlier results still pending");

  // The flush index stays inside the run of held blanks.
  a_flush_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == psct_pkg::SQ_FLUSH) |-> (flush_idx_r < plan_r.flush_len))
    else $error("blank flush index out of range");

  // A row end always closes its request.
  a_row_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == psct_pkg::K_ROW) |-> out_last_r)
    else $error("row end not flagged as final result");

  // A loaded token that is not last is followed by another token of the same request.
  a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !ld_last) |=> (seq_r != psct_pkg::SQ_IDLE))
    else $error("sequencer went idle after a non-final token");
`endif

endmodule

// ===== sim/tb_pipe_separated_cell_tokenizer.sv =====
`timescale 1ns / 1ps
// Testbench of the pipe-separated cell tokenizer: directed and random text files checked against a token predictor.
module tb_pipe_separated_cell_tokenizer;

  // One expected token, as it should leave the result channel.
  typedef struct packed {
    psct_pkg::kind_t kind;
    logic [7:0]      data;
    psct_pkg::err_t  err;
    logic            last;
  } token_t;

  // Token predictor plus the queue of tokens still owed by the block.
  class cell_token_scoreboard;
    psct_pkg::mode_t mode;
    logic [7:0]      held [psct_pkg::BLANK_BUFFER_DEPTH];
    int unsigned     held_cnt;
    bit              after_cr;
    bit              halted;
    token_t          token_q[$];
    int unsigned     mismatches;
    int unsigned     requests;
    int unsigned     tokens;
    int unsigned     error_tokens;

    function new();
      rewind();
      mismatches   = 0;
      requests     = 0;
      tokens       = 0;
      error_tokens = 0;
    endfunction

    // Return to file start; the blank store keeps stale bytes, never read at or above held_cnt.
    function void rewind();
      mode     = psct_pkg::M_FILE_START;
      held_cnt = 0;
      after_cr = 1'b0;
      halted   = 1'b0;
    endfunction

    function bit line_end(logic [7:0] c);
      return c == psct_pkg::CH_CR || c == psct_pkg::CH_LF;
    endfunction

    function bit trim_blank(logic [7:0] c);
      return c == psct_pkg::CH_SPACE || c == psct_pkg::CH_TAB || c == psct_pkg::CH_VT;
    endfunction

    function bit indent_blank(logic [7:0] c);
      return trim_blank(c) || c == psct_pkg::CH_FF;
    endfunction

    function void emit(psct_pkg::kind_t k, logic [7:0] b, psct_pkg::err_t e);
      token_t t;
      t.kind = k;
      t.data = (k == psct_pkg::K_CONTENT) ? b : 8'h00;
      t.err  = (k == psct_pkg::K_ERROR) ? e : psct_pkg::ERR_UNCLOSED;
      t.last = 1'b0;
      token_q = {token_q, t};
    endfunction

    function void finish_line(logic [7:0] c);
      after_cr = (c == psct_pkg::CH_CR);
      mode     = psct_pkg::M_LINE_START;
    endfunction

    function void close_row(logic [7:0] c);
      held_cnt = 0;
      emit(psct_pkg::K_CELL, 8'h00, psct_pkg::ERR_UNCLOSED);
      emit(psct_pkg::K_ROW, 8'h00, psct_pkg::ERR_UNCLOSED);
      finish_line(c);
    endfunction

    function void open_cell(logic [7:0] c);
      held_cnt = 0;
      if (c == psct_pkg::CH_QUOTE) begin
        mode = psct_pkg::M_QUOTED;
      end else if (c == psct_pkg::CH_PIPE) begin
        emit(psct_pkg::K_CELL, 8'h00, psct_pkg::ERR_UNCLOSED);
        mode = psct_pkg::M_CELL_START;
      end else if (line_end(c)) begin
        close_row(c);
      end else if (trim_blank(c)) begin
        held[0]  = c;
        held_cnt = 1;
        mode     = psct_pkg::M_UNQUOTED;
      end else begin
        emit(psct_pkg::K_CONTENT, c, psct_pkg::ERR_UNCLOSED);
        mode = psct_pkg::M_UNQUOTED;
      end
    endfunction

    function void past_quote(logic [7:0] c);
      if (c == psct_pkg::CH_PIPE) begin
        emit(psct_pkg::K_CELL, 8'h00, psct_pkg::ERR_UNCLOSED);
        mode = psct_pkg::M_CELL_START;
      end else if (line_end(c)) begin
        close_row(c);
      end else if (trim_blank(c)) begin
        mode = psct_pkg::M_AFTER_QUOTE;
      end else begin
        emit(psct_pkg::K_ERROR, 8'h00, psct_pkg::ERR_JUNK);
        halted = 1'b1;
      end
    endfunction

    // Advance the predictor by one accepted request and queue the tokens it owes.
    function void note_request(logic [7:0] c, logic eoi);
      int unsigned first;
      first = token_q.size();
      requests++;
      if (eoi) begin
        if (!halted) begin
          if (mode == psct_pkg::M_QUOTED) begin
            emit(psct_pkg::K_ERROR, 8'h00, psct_pkg::ERR_UNCLOSED);
          end else if (mode == psct_pkg::M_CELL_START || mode == psct_pkg::M_UNQUOTED ||
                       mode == psct_pkg::M_QUOTE_SEEN || mode == psct_pkg::M_AFTER_QUOTE) begin
            emit(psct_pkg::K_CELL, 8'h00, psct_pkg::ERR_UNCLOSED);
            emit(psct_pkg::K_ROW, 8'h00, psct_pkg::ERR_UNCLOSED);
          end
        end
        rewind();
      end else if (halted) begin
        // drop everything until end of input
      end else if (after_cr && c == psct_pkg::CH_LF) begin
        after_cr = 1'b0;
      end else begin
        after_cr = 1'b0;
        case (mode)
          psct_pkg::M_FILE_START, psct_pkg::M_LINE_START: begin
            if (mode == psct_pkg::M_FILE_START && c == psct_pkg::CH_LBRACK)
              mode = psct_pkg::M_HEADER;
            else if (c == psct_pkg::CH_SEMI) mode = psct_pkg::M_COMMENT;
            else if (line_end(c)) finish_line(c);
            else if (indent_blank(c)) mode = psct_pkg::M_LEAD_BLANK;
            else open_cell(c);
          end
          psct_pkg::M_LEAD_BLANK: begin
            if (line_end(c)) finish_line(c);
            else if (!indent_blank(c)) open_cell(c);
          end
          psct_pkg::M_HEADER, psct_pkg::M_COMMENT: begin
            if (line_end(c)) finish_line(c);
          end
          psct_pkg::M_CELL_START: open_cell(c);
          psct_pkg::M_UNQUOTED: begin
            if (c == psct_pkg::CH_PIPE) begin
              held_cnt = 0;
              emit(psct_pkg::K_CELL, 8'h00, psct_pkg::ERR_UNCLOSED);
              mode = psct_pkg::M_CELL_START;
            end else if (line_end(c)) begin
              close_row(c);
            end else if (trim_blank(c)) begin
              if (held_cnt >= psct_pkg::BLANK_BUFFER_DEPTH) begin
                held_cnt = 0;
                emit(psct_pkg::K_ERROR, 8'h00, psct_pkg::ERR_OVERFLOW);
                halted = 1'b1;
              end else begin
                held[held_cnt] = c;
                held_cnt++;
              end
            end else begin
              for (int unsigned i = 0; i < held_cnt; i++)
                emit(psct_pkg::K_CONTENT, held[i], psct_pkg::ERR_UNCLOSED);
              held_cnt = 0;
              emit(psct_pkg::K_CONTENT, c, psct_pkg::ERR_UNCLOSED);
            end
          end
          psct_pkg::M_QUOTED: begin
            if (c == psct_pkg::CH_QUOTE) mode = psct_pkg::M_QUOTE_SEEN;
            else emit(psct_pkg::K_CONTENT, c, psct_pkg::ERR_UNCLOSED);
          end
          psct_pkg::M_QUOTE_SEEN: begin
            if (c == psct_pkg::CH_QUOTE) begin
              emit(psct_pkg::K_CONTENT, c, psct_pkg::ERR_UNCLOSED);
              mode = psct_pkg::M_QUOTED;
            end else begin
              past_quote(c);
            end
          end
          psct_pkg::M_AFTER_QUOTE: past_quote(c);
          default: mode = psct_pkg::M_LINE_START;
        endcase
      end
      if (token_q.size() > first) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    task report(string what);
      $display("%0t ns: token mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compare one accepted token with the oldest one owed.
    task check_token(logic [1:0] kind, logic [7:0] data, logic [1:0] err, logic last);
      token_t want;
      tokens++;
      if (token_q.size() == 0) begin
        report($sformatf("unexpected token kind %0d byte %02h", kind, data));
        return;
      end
      want = token_q.pop_front();
      if (want.kind == psct_pkg::K_ERROR) error_tokens++;
      if (kind !== want.kind)
        report($sformatf("token_kind %0d, want %0d", kind, want.kind));
      if (data !== want.data)
        report($sformatf("content_byte %02h, want %02h", data, want.data));
      if (err !== want.err)
        report($sformatf("error_code %0d, want %0d", err, want.err));
      if (last !== want.last)
        report($sformatf("last_result %0d, want %0d", last, want.last));
    endtask
  endclass

  localparam int unsigned RANDOM_REQUESTS = 450;
  localparam int unsigned DRAIN_CYCLES    = 32;

  // Structural bytes, used to build noise files.
  localparam logic [7:0] MARKS [10] = '{psct_pkg::CH_PIPE, psct_pkg::CH_QUOTE,
                                        psct_pkg::CH_SEMI, psct_pkg::CH_LBRACK,
                                        psct_pkg::CH_CR, psct_pkg::CH_LF,
                                        psct_pkg::CH_TAB, psct_pkg::CH_VT,
                                        psct_pkg::CH_FF, psct_pkg::CH_SPACE};

  logic clk = 1'b0;
  logic rst_n;

  psct_in_if  in_ch ();
  psct_out_if out_ch ();

  pipe_separated_cell_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cell_token_scoreboard token_board = new();

  logic [7:0]  file_text[$];  // bytes of the file being built, end of input not included
  int unsigned files_played = 0;
  int unsigned fed = 0;       // random-phase bytes that the block did not drop
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs: far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("pipe_separated_cell_tokenizer test failed");
    $finish;
  end

  // Send one request: idle a random number of cycles, then hold valid until accepted.
  // Lower valid only when a gap is drawn, so a back-to-back request keeps it high.
  task automatic send_request(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 7);
    if (!eoi && !token_board.halted) fed++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= c;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    token_board.note_request(c, eoi);
  endtask

  // Play the built file, then close it with an end-of-input request carrying a junk byte.
  task automatic play_file();
    foreach (file_text[i]) send_request(file_text[i], 1'b0);
    send_request(8'($urandom_range(0, 255)), 1'b1);
    files_played++;
  endtask

  function automatic void put_byte(logic [7:0] b);
    file_text = {file_text, b};
  endfunction

  // Any byte that carries no meaning inside a cell; covers the high half too.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == psct_pkg::CH_PIPE || b == psct_pkg::CH_QUOTE || b == psct_pkg::CH_CR ||
           b == psct_pkg::CH_LF || b == psct_pkg::CH_SPACE || b == psct_pkg::CH_TAB ||
           b == psct_pkg::CH_VT)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Cell blanks are space, tab and VT; at line start FF counts as well.
  function automatic logic [7:0] blank_byte(bit lead);
    case ($urandom_range(0, lead ? 3 : 2))
      0: return psct_pkg::CH_SPACE;
      1: return psct_pkg::CH_TAB;
      2: return psct_pkg::CH_VT;
      default: return psct_pkg::CH_FF;
    endcase
  endfunction

  function automatic void add_line_end();
    case ($urandom_range(0, 2))
      0: put_byte(psct_pkg::CH_CR);
      1: put_byte(psct_pkg::CH_LF);
      default: begin
        put_byte(psct_pkg::CH_CR);
        put_byte(psct_pkg::CH_LF);
      end
    endcase
  endfunction

  // One cell: empty, unquoted with blanks before, inside and at the end, or quoted.
  function automatic void add_cell();
    int unsigned pick;
    int unsigned n;
    int unsigned r;
    pick = $urandom_range(0, 9);
    if (pick == 0) return;
    if (pick <= 6) begin
      if (pick == 6) repeat ($urandom_range(1, 3)) put_byte(blank_byte(1'b0));
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) put_byte(blank_byte(1'b0));
        put_byte(plain_byte());
      end
      // Trailing run: mostly short, now and then right around the buffer depth.
      r = $urandom_range(0, 9);
      n = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 3) :
          $urandom_range(psct_pkg::BLANK_BUFFER_DEPTH - 2, psct_pkg::BLANK_BUFFER_DEPTH + 2);
      repeat (n) put_byte(blank_byte(1'b0));
      // Content after the run releases the held blanks.
      if (n > 0 && $urandom_range(0, 1) == 0) put_byte(plain_byte());
    end else begin
      put_byte(psct_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 7))
          0: begin
            put_byte(psct_pkg::CH_QUOTE);
            put_byte(psct_pkg::CH_QUOTE);
          end
          1: put_byte($urandom_range(0, 1) ? psct_pkg::CH_CR : psct_pkg::CH_LF);
          2: put_byte(psct_pkg::CH_PIPE);
          3: put_byte(blank_byte(1'b1));
          default: put_byte(plain_byte());
        endcase
      end
      put_byte(psct_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 2)) put_byte(blank_byte(1'b0));
      if ($urandom_range(0, 11) == 0) put_byte(plain_byte());
    end
  endfunction

  // A mostly well-formed file with random content: optional header, comments, blank lines, rows.
  function automatic void build_file();
    int unsigned lines;
    int unsigned r;
    file_text.delete();
    if ($urandom_range(0, 2) == 0) begin
      put_byte(psct_pkg::CH_LBRACK);
      repeat ($urandom_range(0, 4)) put_byte(plain_byte());
      add_line_end();
    end
    lines = $urandom_range(1, 4);
    for (int unsigned l = 0; l < lines; l++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        put_byte(psct_pkg::CH_SEMI);
        repeat ($urandom_range(0, 4)) put_byte(plain_byte());
        add_line_end();
      end else if (r == 1) begin
        repeat ($urandom_range(0, 3)) put_byte(blank_byte(1'b1));
        add_line_end();
      end else begin
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_byte(blank_byte(1'b1));
        r = $urandom_range(1, 4);
        for (int unsigned c = 0; c < r; c++) begin
          if (c > 0) put_byte(psct_pkg::CH_PIPE);
          add_cell();
        end
        if ($urandom_range(0, 5) == 0) put_byte(psct_pkg::CH_PIPE);
        // The last row may run straight into end of input.
        if (l + 1 < lines || $urandom_range(0, 2) != 0) add_line_end();
      end
    end
    // Now and then leave a quote open at end of input.
    if ($urandom_range(0, 14) == 0) begin
      put_byte(psct_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 3)) put_byte(plain_byte());
    end
  endfunction

  // Noise: raw bytes mixed with structural ones.
  function automatic void build_noise();
    file_text.delete();
    repeat ($urandom_range(3, 20)) begin
      if ($urandom_range(0, 1) == 0) put_byte(8'($urandom_range(0, 255)));
      else put_byte(MARKS[$urandom_range(0, 9)]);
    end
  endfunction

  // Result side: stall a random number of cycles per token, then take one and check it.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      token_board.check_token(out_ch.token_kind, out_ch.content_byte,
                              out_ch.error_code, out_ch.last_result);
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed file: header with CR LF, comment, semicolon after leading blanks as content,
    // pipe before line end, doubled quote and blank after the closing quote, extreme bytes,
    // a held blank released by content, and end of input inside a row.
    file_text = {psct_pkg::CH_LBRACK, 8'h78, psct_pkg::CH_CR, psct_pkg::CH_LF,
                 psct_pkg::CH_SEMI, 8'h63, psct_pkg::CH_LF,
                 psct_pkg::CH_SPACE, psct_pkg::CH_FF, psct_pkg::CH_SEMI,
                 psct_pkg::CH_PIPE, psct_pkg::CH_LF,
                 psct_pkg::CH_QUOTE, 8'h61, psct_pkg::CH_QUOTE, psct_pkg::CH_QUOTE,
                 psct_pkg::CH_QUOTE, psct_pkg::CH_SPACE, psct_pkg::CH_PIPE,
                 8'hFF, 8'h00, psct_pkg::CH_SPACE, 8'h62};
    play_file();
    // Junk after a closing quote halts; the next byte is dropped.
    file_text = {psct_pkg::CH_QUOTE, psct_pkg::CH_QUOTE, 8'h78, 8'h79};
    play_file();
    // End of input inside a quoted cell.
    file_text = {psct_pkg::CH_QUOTE};
    play_file();

    // Random phase: mostly well-formed files, some noise.
    fed = 0;
    while (fed < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 5) == 0) build_noise();
      else build_file();
      play_file();
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every owed token, then watch for strays.
    while (token_board.token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d files and %0d requests; %0d tokens checked, %0d of them errors.",
             files_played, token_board.requests, token_board.tokens, token_board.error_tokens);
    if (token_board.mismatches == 0) begin
      $display("pipe_separated_cell_tokenizer test passed");
    end else begin
      $display("pipe_separated_cell_tokenizer test failed");
    end
    $finish;
  end

endmodule

// ===== pipe_separated_cell_tokenizer.f =====
sv/psct_pkg.sv
sv/psct_if.sv
sv/psct_blank_buf.sv
sv/psct_lexer.sv
sv/pipe_separated_cell_tokenizer.sv
sim/tb_pipe_separated_cell_tokenizer.sv
